// ===== rtl/ial_pkg.sv =====
// ----------------------------------------------------------------------------
// ial_pkg: shared constants and types of the integer execute unit
// Opcodes, status codes, the control word that travels down the pipeline.
// ----------------------------------------------------------------------------
package ial_pkg;

	localparam int WORD_BITS_DEF = 64;

	localparam logic [6:0] OP_ADD  = 7'h20;
	localparam logic [6:0] OP_ADDU = 7'h22;
	localparam logic [6:0] OP_SUB  = 7'h24;
	localparam logic [6:0] OP_SUBU = 7'h26;
	localparam logic [6:0] OP_MUL  = 7'h28;
	localparam logic [6:0] OP_MULU = 7'h2A;
	localparam logic [6:0] OP_DIV  = 7'h2C;
	localparam logic [6:0] OP_DIVU = 7'h2E;
	localparam logic [6:0] OP_SL   = 7'h34;
	localparam logic [6:0] OP_SR   = 7'h38;
	localparam logic [6:0] OP_SRU  = 7'h3A;
	localparam logic [6:0] OP_CMP  = 7'h3C;
	localparam logic [6:0] OP_CMPU = 7'h3E;
	localparam logic [6:0] OP_AND  = 7'h40;
	localparam logic [6:0] OP_OR   = 7'h42;
	localparam logic [6:0] OP_XOR  = 7'h44;
	localparam logic [6:0] OP_ANDN = 7'h46;
	localparam logic [6:0] OP_ORN  = 7'h48;
	localparam logic [6:0] OP_NAND = 7'h4A;
	localparam logic [6:0] OP_NOR  = 7'h4C;
	localparam logic [6:0] OP_NXOR = 7'h4E;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_DIVZ    = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	typedef struct packed {
		logic       is_mul;
		logic       is_div;
		logic       neg_q;
		logic       neg_r;
		logic       wr;
		logic       remv;
		logic       ovf;
		logic [1:0] status;
	} ctrl_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} front_en_t;

endpackage

// ===== rtl/ial_front.sv =====
// ----------------------------------------------------------------------------
// ial_front: operand capture, decode and multiply
// Three stages: operand select, decode with simple results and partial
// products, product sum and divider setup.
// ----------------------------------------------------------------------------
module ial_front #(
	parameter int W = ial_pkg::WORD_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ial_pkg::front_en_t en,
	input  logic              in_valid,
	input  logic [6:0]        req_type,
	input  logic [63:0]       y_value,
	input  logic [63:0]       z_reg_value,
	input  logic [7:0]        z_field,
	output ial_pkg::front_en_t vld,
	output ial_pkg::ctrl_t    out_ctrl,
	output logic [W-1:0]      out_p,
	output logic [W-1:0]      out_d,
	output logic [W-1:0]      out_div
);
	import ial_pkg::*;

	localparam int H  = (W + 1) / 2;
	localparam int LW = W - H;

	logic         v_s1, v_s2, v_s3;
	logic [6:0]   op_s1;
	logic [W-1:0] y_s1, z_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en.s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			op_s1 <= req_type;
			y_s1  <= y_value[W-1:0];
			z_s1  <= req_type[0] ? W'(z_field) : z_reg_value[W-1:0];
		end
	end

	// Decode and the simple operations.
	ctrl_t        c_d;
	logic [W-1:0] r_d, dv_d, sum, dif, ya, za;
	logic [5:0]   sh;
	logic         yn, zn;

	always_comb begin
		sum = y_s1 + z_s1;
		dif = y_s1 - z_s1;
		sh  = z_s1[5:0];
		yn  = y_s1[W-1];
		zn  = z_s1[W-1];
		ya  = yn ? (W'(0) - y_s1) : y_s1;
		za  = zn ? (W'(0) - z_s1) : z_s1;
		c_d = '0;
		c_d.wr = 1'b1;
		c_d.status = ST_OK;
		r_d  = '0;
		dv_d = z_s1;
		case ({op_s1[6:1], 1'b0})
			OP_ADD: begin
				r_d = sum;
				c_d.ovf = (y_s1[W-1] ^ sum[W-1]) & (z_s1[W-1] ^ sum[W-1]);
			end
			OP_ADDU: r_d = sum;
			OP_SUB: begin
				r_d = dif;
				c_d.ovf = (y_s1[W-1] ^ z_s1[W-1]) & (y_s1[W-1] ^ dif[W-1]);
			end
			OP_SUBU: r_d = dif;
			OP_MUL, OP_MULU: c_d.is_mul = 1'b1;
			OP_DIV: begin
				if (z_s1 == '0) begin
					c_d.wr = 1'b0;
					c_d.status = ST_DIVZ;
				end else begin
					c_d.is_div = 1'b1;
					c_d.remv = 1'b1;
					c_d.neg_q = yn ^ zn;
					c_d.neg_r = yn;
					r_d  = ya;
					dv_d = za;
				end
			end
			OP_DIVU: begin
				if (z_s1 == '0) begin
					c_d.wr = 1'b0;
					c_d.status = ST_DIVZ;
				end else begin
					c_d.is_div = 1'b1;
					c_d.remv = 1'b1;
					r_d = y_s1;
				end
			end
			OP_SL:  r_d = y_s1 << sh;
			OP_SR:  r_d = W'($signed(y_s1) >>> sh);
			OP_SRU: r_d = y_s1 >> sh;
			OP_CMP: begin
				if ($signed(y_s1) < $signed(z_s1)) r_d = '1;
				else r_d = (y_s1 == z_s1) ? W'(0) : W'(1);
			end
			OP_CMPU: begin
				if (y_s1 < z_s1) r_d = '1;
				else r_d = (y_s1 == z_s1) ? W'(0) : W'(1);
			end
			OP_AND:  r_d = y_s1 & z_s1;
			OP_OR:   r_d = y_s1 | z_s1;
			OP_XOR:  r_d = y_s1 ^ z_s1;
			OP_ANDN: r_d = y_s1 & ~z_s1;
			OP_ORN:  r_d = y_s1 | ~z_s1;
			OP_NAND: r_d = ~(y_s1 & z_s1);
			OP_NOR:  r_d = ~(y_s1 | z_s1);
			OP_NXOR: r_d = ~(y_s1 ^ z_s1);
			default: begin
				c_d.wr = 1'b0;
				c_d.status = ST_INVALID;
			end
		endcase
	end

	ctrl_t         c_s2;
	logic [W-1:0]  r_s2, dv_s2;
	logic [2*H-1:0] pll_s2;
	logic [LW-1:0] phl_s2, plh_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en.s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			c_s2   <= c_d;
			r_s2   <= r_d;
			dv_s2  <= dv_d;
			pll_s2 <= (2*H)'(y_s1[H-1:0]) * (2*H)'(z_s1[H-1:0]);
			phl_s2 <= y_s1[W-1:H] * z_s1[LW-1:0];
			plh_s2 <= y_s1[LW-1:0] * z_s1[W-1:H];
		end
	end

	logic [W-1:0] mulr;
	assign mulr = pll_s2[W-1:0] + {phl_s2 + plh_s2, {H{1'b0}}};

	ctrl_t        c_s3;
	logic [W-1:0] d_s3, dv_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en.s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			c_s3  <= c_s2;
			d_s3  <= c_s2.is_mul ? mulr : r_s2;
			dv_s3 <= dv_s2;
		end
	end

	assign vld.s1   = v_s1;
	assign vld.s2   = v_s2;
	assign vld.s3   = v_s3;
	assign out_ctrl = c_s3;
	assign out_p    = '0;
	assign out_d    = d_s3;
	assign out_div  = dv_s3;

endmodule

// ===== rtl/ial_div_cell.sv =====
// ----------------------------------------------------------------------------
// ial_div_cell: one restoring divide step
// Shifts one dividend bit into the partial remainder and forms one quotient
// bit; beats that are not divides pass through unchanged.
// ----------------------------------------------------------------------------
module ial_div_cell #(
	parameter int W = ial_pkg::WORD_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  ial_pkg::ctrl_t in_ctrl,
	input  logic [W-1:0]   in_p,
	input  logic [W-1:0]   in_d,
	input  logic [W-1:0]   in_div,
	output logic           out_valid,
	output ial_pkg::ctrl_t out_ctrl,
	output logic [W-1:0]   out_p,
	output logic [W-1:0]   out_d,
	output logic [W-1:0]   out_div
);
	import ial_pkg::*;

	logic [W+1:0] diff;
	logic         ge;
	logic [W-1:0] p_n, d_n;

	always_comb begin
		diff = {1'b0, in_p, in_d[W-1]} - {2'b00, in_div};
		ge   = ~diff[W+1];
		if (in_ctrl.is_div) begin
			p_n = ge ? diff[W-1:0] : {in_p[W-2:0], in_d[W-1]};
			d_n = {in_d[W-2:0], ge};
		end else begin
			p_n = in_p;
			d_n = in_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_ctrl <= in_ctrl;
			out_p    <= p_n;
			out_d    <= d_n;
			out_div  <= in_div;
		end
	end

endmodule

// ===== rtl/integer_alu_execute.sv =====
// Throughput: one beat per cycle while the output is not stalled by m_axis_tready;
// the divider is a chain of WORD_BITS cells, one quotient bit per cell, and every
// stage advances on its own so bubbles close up.
// Reset: arst_n clears all valid flags asynchronously; payload registers keep
// whatever they hold.
// ----------------------------------------------------------------------------
// integer_alu_execute: pipelined 64-bit integer execute unit
// Add, subtract, multiply, divide, shifts, compares and logical operations.
// ----------------------------------------------------------------------------
module integer_alu_execute #(
	parameter int WORD_BITS = ial_pkg::WORD_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// req_type[6:0], y_value[70:7], z_reg_value[134:71], z_field[142:135]
	input  logic [143:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// result[63:0], write_dest[64], remainder[128:65], remainder_valid[129],
	// overflow[130], status[132:131]
	output logic [135:0] m_axis_tdata
);
	import ial_pkg::*;

	localparam int W = WORD_BITS;

	front_en_t fen, fvld;
	ctrl_t     c_ch [W+1];
	logic [W-1:0] p_ch [W+1];
	logic [W-1:0] d_ch [W+1];
	logic [W-1:0] dv_ch [W+1];
	logic [W:0]   v_ch;
	logic [W-1:0] cen;
	logic         out_en;

	ial_front #(.W(W)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (fen),
		.in_valid   (s_axis_tvalid),
		.req_type   (s_axis_tdata[6:0]),
		.y_value    (s_axis_tdata[70:7]),
		.z_reg_value(s_axis_tdata[134:71]),
		.z_field    (s_axis_tdata[142:135]),
		.vld        (fvld),
		.out_ctrl   (c_ch[0]),
		.out_p      (p_ch[0]),
		.out_d      (d_ch[0]),
		.out_div    (dv_ch[0])
	);

	assign v_ch[0] = fvld.s3;

	for (genvar i = 0; i < W; i++) begin : g_cell
		ial_div_cell #(.W(W)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (cen[i]),
			.in_valid (v_ch[i]),
			.in_ctrl  (c_ch[i]),
			.in_p     (p_ch[i]),
			.in_d     (d_ch[i]),
			.in_div   (dv_ch[i]),
			.out_valid(v_ch[i+1]),
			.out_ctrl (c_ch[i+1]),
			.out_p    (p_ch[i+1]),
			.out_d    (d_ch[i+1]),
			.out_div  (dv_ch[i+1])
		);
	end

	// A stage may load when it is empty or when the stage after it loads too.
	assign out_en = !m_axis_tvalid || m_axis_tready;
	always_comb begin
		cen[W-1] = !v_ch[W] || out_en;
		for (int i = W - 2; i >= 0; i--) begin
			cen[i] = !v_ch[i+1] || cen[i+1];
		end
		fen.s3 = !v_ch[0] || cen[0];
		fen.s2 = !fvld.s2 || fen.s3;
		fen.s1 = !fvld.s1 || fen.s2;
	end
	assign s_axis_tready = fen.s1;

	// Sign fix-up of the quotient and remainder.
	ctrl_t        cl;
	logic [W-1:0] res_n, rem_n;
	assign cl    = c_ch[W];
	assign res_n = cl.neg_q ? (W'(0) - d_ch[W]) : d_ch[W];
	assign rem_n = !cl.remv ? W'(0) : (cl.neg_r ? (W'(0) - p_ch[W]) : p_ch[W]);

	logic         ov_q;
	logic [63:0]  res_q, rem_q;
	logic         wr_q, remv_q, ovf_q;
	logic [1:0]   st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (out_en) begin
			ov_q <= v_ch[W];
		end
	end

	always_ff @(posedge clk) begin
		if (out_en) begin
			res_q  <= 64'(res_n);
			rem_q  <= 64'(rem_n);
			wr_q   <= cl.wr;
			remv_q <= cl.remv;
			ovf_q  <= cl.ovf;
			st_q   <= cl.status;
		end
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = {3'b000, st_q, ovf_q, remv_q, rem_q, wr_q, res_q};

	a_nowr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !wr_q |-> res_q == 64'd0)
		else $error("unwritten result is not zero");
	a_remv_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && remv_q |-> wr_q && st_q == ST_OK && !ovf_q)
		else $error("remainder flagged on a failed or non-divide beat");
	a_status_wr: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (wr_q == (st_q == ST_OK)))
		else $error("write flag disagrees with status");

endmodule
